// ===== sv/fuppd_pkg.sv =====
// Shared types, constants and character tables for the file URI percent decoder.
package fuppd_pkg;

    localparam int PREFIX_LEN  = 7;
    localparam int HOST_LEN    = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] SLASH_CHAR = 8'h2F;

    // Phase of the URI parser.
    typedef enum logic [3:0] {
        PH_PREFIX = 4'b0001,
        PH_HOST   = 4'b0010,
        PH_DECODE = 4'b0100,
        PH_PASS   = 4'b1000
    } phase_t;

    // Escape tracking inside the path.
    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_PCT  = 3'b010,
        ESC_DIG  = 3'b100
    } esc_t;

    // One queued work item: a run of table characters, then up to three literal bytes.
    typedef struct packed {
        logic            last;
        logic            host_src;
        logic [3:0]      text_cnt;
        logic [1:0]      byte_cnt;
        logic [2:0][7:0] bytes;
    } cmd_t;

    function automatic logic [7:0] scheme_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h66; // f
            4'd1:    c = 8'h69; // i
            4'd2:    c = 8'h6C; // l
            4'd3:    c = 8'h65; // e
            4'd4:    c = 8'h3A; // :
            4'd5:    c = 8'h2F; // /
            4'd6:    c = 8'h2F; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] host_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h6C; // l
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h63; // c
            4'd3:    c = 8'h61; // a
            4'd4:    c = 8'h6C; // l
            4'd5:    c = 8'h68; // h
            4'd6:    c = 8'h6F; // o
            4'd7:    c = 8'h73; // s
            4'd8:    c = 8'h74; // t
            4'd9:    c = 8'h2F; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Letters of either case have 1..6 in the low nibble, so adding nine gives 10..15.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return is_digit(c) ? c[3:0] : (c[3:0] + 4'd9);
    endfunction

endpackage

// ===== sv/file_uri_percent_decoder.sv =====
// Top level of the file URI percent decoder: front classifier, work queue, back expander.
//
//  Channel   Direction  tdata            tuser      tlast
//  s_axis    in         [7:0] in_byte    -          in_last
//  m_axis    out        [7:0] out_byte   has_byte   out_last
//
// The front takes one byte per cycle while the queue has room; the back sends one
// result per cycle unless the output stalls; an item gives at most ten results (on a
// mismatch inside the prefix or host text). A result passes through the queue
// entry and the output register. Reset clears the parser state, queue and output valid.
// Either side may stall; the queue of QUEUE_DEPTH entries lets the other keep going.
module file_uri_percent_decoder
#(
    parameter int QUEUE_DEPTH = fuppd_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] has_byte
    output logic       m_axis_tlast
);

    fuppd_pkg::cmd_t push_cmd, head_cmd;
    logic            push, q_ready, head_valid, pop;

    assign s_axis_tready = q_ready;

    fuppd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (q_ready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .push     (push),
        .cmd      (push_cmd)
    );

    fuppd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    fuppd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .has_byte   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

// ===== sv/fuppd_front.sv =====
// Front part: accepts URI bytes, tracks prefix, host and escape state, issues work items.
module fuppd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output fuppd_pkg::cmd_t   cmd
);

    fuppd_pkg::phase_t phase_reg, phase_next;
    fuppd_pkg::esc_t   esc_reg, esc_next;
    logic [3:0]        match_reg, match_next;
    logic [7:0]        digit_reg, digit_next;

    fuppd_pkg::esc_t   esc_in, d_esc;
    logic [2:0][7:0]   d_bytes;
    logic [1:0]        d_cnt;
    logic [7:0]        d_digit;
    logic              plain;
    logic [3:0]        m1;
    logic              accept;

    assign accept = in_valid && in_ready;
    assign m1     = match_reg + 4'd1;

    // Percent decoding of one byte, shared by the host-mismatch and decode phases.
    always_comb
    begin
        esc_in  = (phase_reg == fuppd_pkg::PH_HOST) ? fuppd_pkg::ESC_NONE : esc_reg;
        d_bytes = '0;
        d_cnt   = 2'd0;
        d_esc   = fuppd_pkg::ESC_NONE;
        d_digit = digit_reg;
        plain   = 1'b1;
        case (esc_in)
            fuppd_pkg::ESC_PCT:
            begin
                if (fuppd_pkg::is_hex(in_byte))
                begin
                    d_digit = in_byte;
                    d_esc   = fuppd_pkg::ESC_DIG;
                    plain   = 1'b0;
                end
                else
                begin
                    d_bytes[0] = fuppd_pkg::PCT_CHAR;
                    d_cnt      = 2'd1;
                end
            end
            fuppd_pkg::ESC_DIG:
            begin
                if (fuppd_pkg::is_hex(in_byte))
                begin
                    d_bytes[0] = {fuppd_pkg::hex_val(digit_reg), fuppd_pkg::hex_val(in_byte)};
                    d_cnt      = 2'd1;
                    plain      = 1'b0;
                end
                else
                begin
                    d_bytes[0] = fuppd_pkg::PCT_CHAR;
                    d_bytes[1] = digit_reg;
                    d_cnt      = 2'd2;
                end
            end
            default:
            begin
                plain = 1'b1;
            end
        endcase
        // A byte that did not continue an escape is looked at afresh.
        if (plain)
        begin
            if (in_byte == fuppd_pkg::PCT_CHAR)
            begin
                d_esc = fuppd_pkg::ESC_PCT;
            end
            else
            begin
                d_bytes[d_cnt] = in_byte;
                d_cnt          = d_cnt + 2'd1;
            end
        end
        // An escape still open at the final byte comes out literally.
        if (in_last)
        begin
            if (d_esc == fuppd_pkg::ESC_PCT)
            begin
                d_bytes[d_cnt] = fuppd_pkg::PCT_CHAR;
                d_cnt          = d_cnt + 2'd1;
            end
            else if (d_esc == fuppd_pkg::ESC_DIG)
            begin
                d_bytes[d_cnt]        = fuppd_pkg::PCT_CHAR;
                d_bytes[d_cnt + 2'd1] = d_digit;
                d_cnt                 = d_cnt + 2'd2;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        match_next = match_reg;
        esc_next   = esc_reg;
        digit_next = digit_reg;
        cmd        = '0;
        case (phase_reg)
            fuppd_pkg::PH_PREFIX:
            begin
                if ((match_reg < 4'(fuppd_pkg::PREFIX_LEN)) &&
                    (in_byte == fuppd_pkg::scheme_char(match_reg)))
                begin
                    if (m1 == 4'(fuppd_pkg::PREFIX_LEN))
                    begin
                        phase_next = fuppd_pkg::PH_HOST;
                        match_next = 4'd0;
                    end
                    else
                    begin
                        match_next = m1;
                        if (in_last)
                        begin
                            cmd.text_cnt = m1;
                        end
                    end
                end
                else
                begin
                    cmd.text_cnt = match_reg;
                    cmd.bytes[0] = in_byte;
                    cmd.byte_cnt = 2'd1;
                    phase_next   = fuppd_pkg::PH_PASS;
                    match_next   = 4'd0;
                end
            end
            fuppd_pkg::PH_HOST:
            begin
                cmd.host_src = 1'b1;
                if ((match_reg < 4'(fuppd_pkg::HOST_LEN)) &&
                    (in_byte == fuppd_pkg::host_char(match_reg)))
                begin
                    if (m1 == 4'(fuppd_pkg::HOST_LEN))
                    begin
                        cmd.bytes[0] = fuppd_pkg::SLASH_CHAR;
                        cmd.byte_cnt = 2'd1;
                        phase_next   = fuppd_pkg::PH_DECODE;
                        match_next   = 4'd0;
                    end
                    else
                    begin
                        match_next = m1;
                        if (in_last)
                        begin
                            cmd.text_cnt = m1;
                        end
                    end
                end
                else
                begin
                    cmd.text_cnt = match_reg;
                    cmd.bytes    = d_bytes;
                    cmd.byte_cnt = d_cnt;
                    esc_next     = d_esc;
                    digit_next   = d_digit;
                    phase_next   = fuppd_pkg::PH_DECODE;
                    match_next   = 4'd0;
                end
            end
            fuppd_pkg::PH_DECODE:
            begin
                cmd.bytes    = d_bytes;
                cmd.byte_cnt = d_cnt;
                esc_next     = d_esc;
                digit_next   = d_digit;
            end
            fuppd_pkg::PH_PASS:
            begin
                cmd.bytes[0] = in_byte;
                cmd.byte_cnt = 2'd1;
            end
            default:
            begin
                phase_next = fuppd_pkg::PH_PREFIX;
            end
        endcase
        cmd.last = in_last;
        // The final byte always starts the next URI from a clean state.
        if (in_last)
        begin
            phase_next = fuppd_pkg::PH_PREFIX;
            match_next = 4'd0;
            esc_next   = fuppd_pkg::ESC_NONE;
            digit_next = 8'd0;
        end
    end

    assign push = accept && (in_last || (cmd.text_cnt != 4'd0) || (cmd.byte_cnt != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fuppd_pkg::PH_PREFIX;
            match_reg <= 4'd0;
            esc_reg   <= fuppd_pkg::ESC_NONE;
            digit_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            match_reg <= match_next;
            esc_reg   <= esc_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== sv/fuppd_queue.sv =====
// Short register queue of work items between the front and back parts.
module fuppd_queue
#(
    parameter int DEPTH = fuppd_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fuppd_pkg::cmd_t push_cmd,
    output logic            ready,
    input  logic            pop,
    output logic            head_valid,
    output fuppd_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fuppd_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign ready      = (count_reg < CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/fuppd_back.sv =====
// Back part: expands each work item into registered result bytes, one per cycle unless stalled.
module fuppd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  fuppd_pkg::cmd_t head_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            has_byte,
    output logic            out_last
);

    logic [3:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       has_reg, last_reg;

    logic [4:0] total;
    logic [3:0] end_idx;
    logic [1:0] sel;
    logic       final_one;
    logic       load;
    logic [7:0] lit_byte, char_now;

    assign total     = {1'b0, head_cmd.text_cnt} + {3'b000, head_cmd.byte_cnt};
    assign end_idx   = (total == 5'd0) ? 4'd0 : 4'(total - 5'd1);
    assign final_one = (idx_reg == end_idx);
    assign sel       = 2'(idx_reg - head_cmd.text_cnt);
    assign load      = head_valid && (!valid_reg || out_ready);
    assign pop       = load && final_one;

    always_comb
    begin
        case (sel)
            2'd1:    lit_byte = head_cmd.bytes[1];
            2'd2:    lit_byte = head_cmd.bytes[2];
            default: lit_byte = head_cmd.bytes[0];
        endcase
        if (total == 5'd0)
        begin
            char_now = 8'd0;
        end
        else if (idx_reg < head_cmd.text_cnt)
        begin
            char_now = head_cmd.host_src ? fuppd_pkg::host_char(idx_reg)
                                         : fuppd_pkg::scheme_char(idx_reg);
        end
        else
        begin
            char_now = lit_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_one ? 4'd0 : idx_reg + 4'd1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= char_now;
            has_reg  <= (total != 5'd0);
            last_reg <= head_cmd.last && final_one;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign out_last  = last_reg;

endmodule
